/* design/mmst_pkg.sv */
// ----------------------------------------------------------------------------
// mmst_pkg: shared types and constants for the sparse-triplet matrix multiply
// Request and result codes, register indexes, result widths and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mmst_pkg;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned VAL_W   = 36;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned IDX_W   = 4;   // width of row/col fields
  localparam int unsigned ELEM_IN_W = 16;

  // out_col can only name the first 16 columns
  localparam int unsigned OUT_COL_REACH = 16;

  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = 9'd511;

  localparam logic [1:0] CFG_ROWS_A  = 2'd0;
  localparam logic [1:0] CFG_INNER_A = 2'd1;
  localparam logic [1:0] CFG_ROWS_B  = 2'd2;
  localparam logic [1:0] CFG_COLS_B  = 2'd3;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_TRIP    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_DIM_ERR = 2'd2,
    KIND_ROW_ERR = 2'd3
  } kind_e;

  typedef struct packed {
    logic  clr_wr;      // write zero at the sweep address in both stores
    logic  load_a;      // write input element into A
    logic  load_b;      // write input element into B
    logic  cnt_clr;     // clear the nonzero count
    logic  cap_row;     // capture the requested row
    logic  acc_clr;     // start a new column sum
    logic  mac_issue;   // read one A/B pair into the MAC pipe
    logic  emit;        // load the output register
    kind_e kind;        // kind of the item being emitted
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;    // MAC pipe still holds products
    logic acc_nz;       // column sum is nonzero
    logic out_free;     // output register can take an item this cycle
  } sts_t;

endpackage

/* design/mmst_datapath.sv */
// ----------------------------------------------------------------------------
// mmst_datapath: element stores, MAC pipeline, count and output register
// Two single-port-write, registered-read stores; a read -> multiply ->
// accumulate pipe; the saturating nonzero count; the result register.
// ----------------------------------------------------------------------------
module mmst_datapath #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned KW         = $clog2(MAX_DIM + 1),
  parameter int unsigned AW         = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mmst_pkg::cmd_t                   cmd_i,
  output mmst_pkg::sts_t                   sts_o,
  input  logic [KW-1:0]                    k_i,
  input  logic [KW-1:0]                    j_i,
  input  logic [AW-1:0]                    clr_addr_i,
  input  logic [mmst_pkg::IDX_W-1:0]       row_i,
  input  logic [mmst_pkg::IDX_W-1:0]       col_i,
  input  logic signed [mmst_pkg::ELEM_IN_W-1:0] value_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [1:0]                       kind_o,
  output logic [mmst_pkg::IDX_W-1:0]       out_row_o,
  output logic [mmst_pkg::IDX_W-1:0]       out_col_o,
  output logic signed [mmst_pkg::VAL_W-1:0] result_value_o,
  output logic [mmst_pkg::CNT_W-1:0]       total_count_o,
  output logic                             last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned PW    = 2 * ELEM_WIDTH;
  localparam int unsigned XW    = (PW > mmst_pkg::VAL_W) ? PW : mmst_pkg::VAL_W;

  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         a_raddr;
  logic [AW-1:0]         b_raddr;
  logic [ELEM_WIDTH-1:0] wr_data;

  logic [mmst_pkg::IDX_W-1:0] row_q;

  logic signed [ELEM_WIDTH-1:0]      rd_a_q, rd_b_q;
  logic signed [PW-1:0]              prod_q;
  logic signed [XW-1:0]              prod_x;
  logic        [mmst_pkg::VAL_W-1:0] acc_q;
  logic                              v1_q, v2_q;

  logic [mmst_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                       trip_emit;

  logic                              ovalid_q;
  mmst_pkg::kind_e                   kind_q;
  logic [mmst_pkg::IDX_W-1:0]        orow_q, ocol_q;
  logic [mmst_pkg::VAL_W-1:0]        oval_q;
  logic [mmst_pkg::CNT_W-1:0]        ocnt_q;
  logic                              olast_q;

  // store addressing: row * MAX_DIM + col
  assign wr_addr = cmd_i.clr_wr ? clr_addr_i
                                : AW'(32'(row_i) * MAX_DIM + 32'(col_i));
  assign wr_data = cmd_i.clr_wr ? '0 : ELEM_WIDTH'(value_i);
  assign a_raddr = AW'(32'(row_q) * MAX_DIM + 32'(k_i));
  assign b_raddr = AW'(32'(k_i) * MAX_DIM + 32'(j_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.load_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.load_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_q <= mem_b[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_row) begin
      row_q <= row_i;
    end
  end

  // MAC pipe: read data -> product -> accumulate (wraps in 36 bits)
  assign prod_x = XW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= rd_a_q * rd_b_q;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + prod_x[mmst_pkg::VAL_W-1:0];
    end
  end

  // nonzero count, saturating
  assign trip_emit = cmd_i.emit && (cmd_i.kind == mmst_pkg::KIND_TRIP);
  assign cnt_inc   = (cnt_q == mmst_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (trip_emit) begin
      cnt_d = cnt_inc;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.kind;
      orow_q  <= row_q;
      olast_q <= (cmd_i.kind != mmst_pkg::KIND_TRIP);
      unique case (cmd_i.kind)
        mmst_pkg::KIND_TRIP: begin
          ocol_q <= mmst_pkg::IDX_W'(j_i);
          oval_q <= acc_q;
          ocnt_q <= cnt_inc;
        end
        mmst_pkg::KIND_DONE: begin
          ocol_q <= '0;
          oval_q <= '0;
          ocnt_q <= cnt_q;
        end
        default: begin
          ocol_q <= '0;
          oval_q <= '0;
          ocnt_q <= '0;
        end
      endcase
    end
  end

  assign sts_o.pipe_busy = v1_q || v2_q;
  assign sts_o.acc_nz    = |acc_q;
  assign sts_o.out_free  = !ovalid_q || !out_stall_i;

  assign out_valid_o    = ovalid_q;
  assign kind_o         = kind_q;
  assign out_row_o      = orow_q;
  assign out_col_o      = ocol_q;
  assign result_value_o = oval_q;
  assign total_count_o  = ocnt_q;
  assign last_o         = olast_q;

endmodule

/* design/mmst_ctrl.sv */
// ----------------------------------------------------------------------------
// mmst_ctrl: request sequencer and dimension registers
// Runs the store clearing sweep, decodes requests, checks dimensions and
// steps the column and inner-product counters of a row computation.
// ----------------------------------------------------------------------------
module mmst_ctrl #(
  parameter int unsigned MAX_DIM = 16,
  parameter int unsigned KW      = $clog2(MAX_DIM + 1),
  parameter int unsigned AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [mmst_pkg::IDX_W-1:0]   row_i,
  input  logic [mmst_pkg::IDX_W-1:0]   col_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [mmst_pkg::CFG_W-1:0]   cfg_data_i,
  input  mmst_pkg::sts_t               sts_i,
  output mmst_pkg::cmd_t               cmd_o,
  output logic [KW-1:0]                k_o,
  output logic [KW-1:0]                j_o,
  output logic [AW-1:0]                clr_addr_o
);

  localparam int unsigned DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned NCOL_MAX = (MAX_DIM < mmst_pkg::OUT_COL_REACH) ?
                                     MAX_DIM : mmst_pkg::OUT_COL_REACH;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_MAC     = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;
  localparam logic [2:0] ST_DIM_ERR = 3'd6;
  localparam logic [2:0] ST_ROW_ERR = 3'd7;

  logic [2:0] state_q, state_d;
  logic [KW-1:0] k_q, k_d, j_q, j_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [mmst_pkg::CFG_W-1:0] rows_a_q, inner_a_q, rows_b_q, cols_b_q;
  logic [KW-1:0] nrows, ninner, ncol;
  logic          load_ok, row_oor, last_col;
  mmst_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q  <= mmst_pkg::DIM_RESET;
      inner_a_q <= mmst_pkg::DIM_RESET;
      rows_b_q  <= mmst_pkg::DIM_RESET;
      cols_b_q  <= mmst_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmst_pkg::CFG_ROWS_A:  rows_a_q  <= cfg_data_i;
        mmst_pkg::CFG_INNER_A: inner_a_q <= cfg_data_i;
        mmst_pkg::CFG_ROWS_B:  rows_b_q  <= cfg_data_i;
        mmst_pkg::CFG_COLS_B:  cols_b_q  <= cfg_data_i;
      endcase
    end
  end

  // dimensions above the store size count as the store size
  assign nrows  = (32'(rows_a_q) > MAX_DIM) ? KW'(MAX_DIM) : KW'(rows_a_q);
  assign ninner = (32'(inner_a_q) > MAX_DIM) ? KW'(MAX_DIM) : KW'(inner_a_q);
  assign ncol   = (32'(cols_b_q) > NCOL_MAX) ? KW'(NCOL_MAX) : KW'(cols_b_q);

  assign load_ok  = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign row_oor  = 32'(row_i) >= 32'(nrows);
  assign last_col = KW'(j_q + 1'b1) == ncol;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    clr_d   = clr_q;
    cmd     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        clr_d      = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mmst_pkg::req_e'(req_type_i))
            mmst_pkg::REQ_LOAD_A: begin
              cmd.load_a  = load_ok;
              cmd.cnt_clr = load_ok;
            end
            mmst_pkg::REQ_LOAD_B: begin
              cmd.load_b  = load_ok;
              cmd.cnt_clr = load_ok;
            end
            mmst_pkg::REQ_COMPUTE: begin
              cmd.cap_row = 1'b1;
              priority if (inner_a_q != rows_b_q) begin
                state_d = ST_DIM_ERR;
              end else if (row_oor) begin
                state_d = ST_ROW_ERR;
              end else if (ncol == '0) begin
                state_d = ST_DONE;
              end else begin
                j_d         = '0;
                k_d         = '0;
                cmd.acc_clr = 1'b1;
                state_d     = (ninner == '0) ? ST_EMIT : ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (KW'(k_q + 1'b1) == ninner) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.acc_nz || sts_i.out_free) begin
          cmd.emit = sts_i.acc_nz;
          cmd.kind = mmst_pkg::KIND_TRIP;
          if (last_col) begin
            state_d = ST_DONE;
          end else begin
            j_d         = j_q + 1'b1;
            k_d         = '0;
            cmd.acc_clr = 1'b1;
            state_d     = (ninner == '0) ? ST_EMIT : ST_MAC;
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = mmst_pkg::KIND_DONE;
          state_d  = ST_IDLE;
        end
      end
      ST_DIM_ERR: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = mmst_pkg::KIND_DIM_ERR;
          state_d  = ST_IDLE;
        end
      end
      ST_ROW_ERR: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = mmst_pkg::KIND_ROW_ERR;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      k_q     <= '0;
      j_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign cmd_o      = cmd;
  assign k_o        = k_q;
  assign j_o        = j_q;
  assign clr_addr_o = clr_q;

  // an item is only written into a free result register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts_i.out_free)
    else $error("emit while result register is occupied");

  // a new column sum never starts with products still in flight
  a_clr_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.acc_clr |-> !sts_i.pipe_busy)
    else $error("accumulator cleared with products in flight");

  // inner index stays inside the stores while reading
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mac_issue |-> (32'(k_q) < MAX_DIM) && (32'(j_q) < NCOL_MAX))
    else $error("MAC read index out of range");

  // stores are never written while a row is being computed
  a_no_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_a || cmd.load_b) |-> (state_q == ST_IDLE) && !sts_i.pipe_busy)
    else $error("store written during computation");

endmodule

/* design/matrix_multiply_sparse_triplets.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_sparse_triplets: row-at-a-time matrix product, triplet output
// Loads A and B element by element; a compute request produces the nonzero
// elements of one result row as (row, column, value) items plus a row-done
// item carrying the running nonzero count, or one error item instead.
// ----------------------------------------------------------------------------
// After reset the block sweeps both element stores to zero, one entry per
// cycle over all MAX_DIM*MAX_DIM entries; input stays stalled meanwhile,
// configuration writes are taken. A load writes its element and leaves the
// block ready for the next request. A compute request runs every column
// through one shared multiply-accumulate pipe (store read, multiply,
// accumulate): each column issues its inner products, drains the pipe and
// emits an item when its sum is nonzero; a stalled result side holds the row.
// Errors and rows with no columns produce a single item.
// A result waiting in the output register does not block new loads.
// ----------------------------------------------------------------------------
module matrix_multiply_sparse_triplets #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [mmst_pkg::IDX_W-1:0]        row_i,
  input  logic [mmst_pkg::IDX_W-1:0]        col_i,
  input  logic signed [mmst_pkg::ELEM_IN_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [mmst_pkg::IDX_W-1:0]        out_row_o,
  output logic [mmst_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [mmst_pkg::VAL_W-1:0] result_value_o,
  output logic [mmst_pkg::CNT_W-1:0]        total_count_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [mmst_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned KW = $clog2(MAX_DIM + 1);
  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  mmst_pkg::cmd_t cmd;
  mmst_pkg::sts_t sts;
  logic [KW-1:0]  k_idx, j_idx;
  logic [AW-1:0]  clr_addr;

  mmst_ctrl #(
    .MAX_DIM (MAX_DIM),
    .KW      (KW),
    .AW      (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .k_o        (k_idx),
    .j_o        (j_idx),
    .clr_addr_o (clr_addr)
  );

  mmst_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .KW         (KW),
    .AW         (AW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .k_i            (k_idx),
    .j_i            (j_idx),
    .clr_addr_i     (clr_addr),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .result_value_o (result_value_o),
    .total_count_o  (total_count_o),
    .last_o         (last_o)
  );

endmodule

/* sim/mmst_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmst_tb_pkg: row predictor and result scoreboard for the triplet multiply
// Keeps its own copy of both element stores, the nonzero count and the
// dimension registers, works out the result items of every accepted request
// and checks each result transfer against the oldest one still waiting.
// ----------------------------------------------------------------------------
package mmst_tb_pkg;
  import mmst_pkg::*;

  localparam int unsigned DIM = 16;            // MAX_DIM of the block under test
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;   // not decoded by the block

  typedef struct {
    kind_e                   kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } row_item_t;

  class triplet_scoreboard;
    logic signed [ELEM_IN_W-1:0] a_elem [DIM*DIM];
    logic signed [ELEM_IN_W-1:0] b_elem [DIM*DIM];
    logic [CNT_W-1:0]            nz_count;
    logic [CFG_W-1:0]            dims [4];
    row_item_t                   expected_q [$];
    int unsigned                 mismatches;

    function new();
      foreach (a_elem[i]) begin
        a_elem[i] = '0;
        b_elem[i] = '0;
      end
      foreach (dims[i]) dims[i] = DIM_RESET;
      nz_count   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
      dims[idx] = data;
    endfunction

    // register values above the store size act as the store size
    function int unsigned clamp_dim(logic [CFG_W-1:0] d);
      return (int'(d) > DIM) ? DIM : int'(d);
    endfunction

    function void push_item(kind_e kind, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic signed [VAL_W-1:0] value, logic [CNT_W-1:0] count,
                            logic last);
      row_item_t item;
      item.kind  = kind;
      item.row   = row;
      item.col   = col;
      item.value = value;
      item.count = count;
      item.last  = last;
      expected_q.push_back(item);
    endfunction

    function void predict_row(logic [IDX_W-1:0] row);
      int unsigned             n_inner;
      int unsigned             n_cols;
      int unsigned             j;
      int unsigned             k;
      longint                  sum;
      logic signed [VAL_W-1:0] wrapped;
      if (dims[CFG_INNER_A] != dims[CFG_ROWS_B]) begin
        push_item(KIND_DIM_ERR, row, '0, '0, '0, 1'b1);
        return;
      end
      if (int'(row) >= clamp_dim(dims[CFG_ROWS_A])) begin
        push_item(KIND_ROW_ERR, row, '0, '0, '0, 1'b1);
        return;
      end
      n_inner = clamp_dim(dims[CFG_INNER_A]);
      n_cols  = clamp_dim(dims[CFG_COLS_B]);
      if (n_cols > OUT_COL_REACH) n_cols = OUT_COL_REACH;
      for (j = 0; j < n_cols; j++) begin
        sum = 0;
        for (k = 0; k < n_inner; k++) begin
          sum += longint'(a_elem[int'(row) * DIM + k]) * longint'(b_elem[k * DIM + j]);
        end
        wrapped = sum[VAL_W-1:0];
        if (wrapped != '0) begin
          if (nz_count != CNT_MAX) nz_count++;
          push_item(KIND_TRIP, row, j[IDX_W-1:0], wrapped, nz_count, 1'b0);
        end
      end
      push_item(KIND_DONE, row, '0, '0, nz_count, 1'b1);
    endfunction

    function void note_request(logic [1:0] req, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col, logic signed [ELEM_IN_W-1:0] value);
      case (req)
        REQ_LOAD_A: begin
          a_elem[int'(row) * DIM + int'(col)] = value;
          nz_count = '0;
        end
        REQ_LOAD_B: begin
          b_elem[int'(row) * DIM + int'(col)] = value;
          nz_count = '0;
        end
        REQ_COMPUTE: predict_row(row);
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic signed [VAL_W-1:0] value, logic [CNT_W-1:0] count,
                               logic last);
      row_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d row %0d col %0d value %0d count %0d last %0b",
                   $time, kind, row, col, value, count, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.kind !== kind || want.row !== row || want.col !== col ||
          want.value !== value || want.count !== count || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch, expected kind %0d row %0d col %0d value %0d count %0d last %0b",
                   $time, want.kind, want.row, want.col, want.value, want.count, want.last);
          $display("%0t:           actual   kind %0d row %0d col %0d value %0d count %0d last %0b",
                   $time, kind, row, col, value, count, last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and checking for matrix_multiply_sparse_triplets
// Directed loads and row requests over the element and dimension extremes and
// the error cases, then random phases of loads and row requests under random
// dimension settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import mmst_pkg::*;
  import mmst_tb_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned RANDOM_REQUESTS = 110;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES     = 1500;
  localparam int unsigned MAX_GAP         = 13;

  localparam logic signed [ELEM_IN_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_IN_W-1:0] ELEM_MAX = 16'sh7fff;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  req_type;
  logic [IDX_W-1:0]            row;
  logic [IDX_W-1:0]            col;
  logic signed [ELEM_IN_W-1:0] elem_value;
  logic                        out_valid;
  logic                        out_stall;
  logic [1:0]                  kind;
  logic [IDX_W-1:0]            out_row;
  logic [IDX_W-1:0]            out_col;
  logic signed [VAL_W-1:0]     result_value;
  logic [CNT_W-1:0]            total_count;
  logic                        last;
  logic                        cfg_we;
  logic [1:0]                  cfg_idx;
  logic [CFG_W-1:0]            cfg_data;

  bit                no_idle = 1'b0;
  bit                hold_rx = 1'b0;
  int unsigned       cycles = 0;
  int unsigned       requests_sent = 0;
  triplet_scoreboard sb = new();

  matrix_multiply_sparse_triplets DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .row_i          (row),
    .col_i          (col),
    .value_i        (elem_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .result_value_o (result_value),
    .total_count_o  (total_count),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
      sb.check_result(kind, out_row, out_col, result_value, total_count, last);
  end

  // result side: random stall before each transfer, one long hold on request
  initial begin : result_sink
    int unsigned wait_cycles;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic logic signed [ELEM_IN_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4:          return ELEM_MIN;
      5:          return ELEM_MAX;
      default:    return ELEM_IN_W'($urandom);
    endcase
  endfunction

  // mostly inside the configured dimension, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_index(logic [CFG_W-1:0] dim);
    int unsigned lim;
    lim = (int'(dim) > DIM) ? DIM : int'(dim);
    if (lim == 0) lim = 1;
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, DIM - 1));
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c,
                              input logic signed [ELEM_IN_W-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    row        <= r;
    col        <= c;
    elem_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, r, c, v);
    if (req != REQ_UNKNOWN) requests_sent++;
  endtask

  // stop offering and wait until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ia,
                          input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
    drain();
    cfg_write(CFG_ROWS_A, ra);
    cfg_write(CFG_INNER_A, ia);
    cfg_write(CFG_ROWS_B, rb);
    cfg_write(CFG_COLS_B, cb);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                 i;
    int unsigned                 n;
    int unsigned                 start;
    logic [CFG_W-1:0]            ra;
    logic [CFG_W-1:0]            ia;
    logic [CFG_W-1:0]            rb;
    logic [CFG_W-1:0]            cb;
    logic signed [ELEM_IN_W-1:0] elem;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    req_type   <= REQ_LOAD_A;
    row        <= '0;
    col        <= '0;
    elem_value <= '0;
    out_stall  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_ROWS_A;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // stores still clear: row done only
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    send_request(REQ_LOAD_A, 4'd0, 4'd0, ELEM_MIN);
    send_request(REQ_LOAD_A, 4'd0, 4'd15, ELEM_MAX);
    send_request(REQ_LOAD_A, 4'd15, 4'd15, ELEM_MAX);
    send_request(REQ_LOAD_B, 4'd0, 4'd0, ELEM_MIN);
    send_request(REQ_LOAD_B, 4'd15, 4'd0, ELEM_MIN);
    send_request(REQ_LOAD_B, 4'd15, 4'd15, ELEM_MAX);
    send_request(REQ_LOAD_B, 4'd0, 4'd15, ELEM_MAX);
    send_request(REQ_UNKNOWN, 4'd15, 4'd15, '1);
    send_request(REQ_COMPUTE, 4'd0, 4'd15, '1);
    send_request(REQ_COMPUTE, 4'd15, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd7, 4'd0, '0);

    // inner dimensions disagree
    set_dims(5'd3, 5'd5, 5'd4, 5'd16);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    // requested row past rows_a
    set_dims(5'd3, 5'd16, 5'd16, 5'd16);
    send_request(REQ_COMPUTE, 4'd3, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd2, 4'd0, '0);
    // no rows at all
    set_dims(5'd0, 5'd0, 5'd0, 5'd0);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    // empty inner dimension: every sum is zero
    set_dims(5'd16, 5'd0, 5'd0, 5'd16);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    // no result columns
    set_dims(5'd16, 5'd16, 5'd16, 5'd0);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    // oversized registers act as 16
    set_dims(5'd31, 5'd31, 5'd31, 5'd31);
    send_request(REQ_COMPUTE, 4'd15, 4'd0, '0);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);
    send_request(REQ_LOAD_A, 4'd0, 4'd1, 16'sd1);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, '0);

    start = requests_sent;

    // outer products of A column 0 and B row 0: enough nonzeros to saturate the
    // count, with the result side held off for a while in the middle
    set_dims(DIM_RESET, 5'd1, 5'd1, DIM_RESET);
    for (i = 0; i < DIM; i++) begin
      do elem = pick_element(); while (elem == '0);
      send_request(REQ_LOAD_B, 4'd0, IDX_W'(i), elem);
    end
    for (i = 0; i < 4; i++) begin
      do elem = pick_element(); while (elem == '0);
      send_request(REQ_LOAD_A, IDX_W'(i), 4'd0, elem);
    end
    no_idle = 1'b1;
    hold_rx = 1'b1;
    for (i = 0; i < 36; i++) begin
      if (i == 18) no_idle = 1'b0;
      send_request(REQ_COMPUTE, IDX_W'($urandom_range(0, 3)), IDX_W'($urandom),
                   ELEM_IN_W'($urandom));
    end

    while (requests_sent - start < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0: begin
          ra = CFG_W'($urandom);
          ia = CFG_W'($urandom);
          rb = ia + CFG_W'($urandom_range(1, 31));
          cb = CFG_W'($urandom);
        end
        1: begin
          ra = CFG_W'($urandom_range(17, 31));
          ia = CFG_W'($urandom_range(17, 31));
          rb = ia;
          cb = CFG_W'($urandom_range(17, 31));
        end
        2: begin
          ra = CFG_W'($urandom_range(0, 16));
          ia = CFG_W'($urandom_range(0, 2));
          rb = ia;
          cb = CFG_W'($urandom_range(0, 2));
        end
        default: begin
          ra = CFG_W'($urandom_range(1, 16));
          ia = CFG_W'($urandom_range(1, 16));
          rb = ia;
          cb = CFG_W'($urandom_range(1, 16));
        end
      endcase
      set_dims(ra, ia, rb, cb);
      no_idle = ($urandom_range(0, 3) == 0);

      n = $urandom_range(3, 10);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          send_request(REQ_LOAD_A, pick_index(ra), pick_index(ia), pick_element());
        else
          send_request(REQ_LOAD_B, pick_index(rb), pick_index(cb), pick_element());
      end

      n = $urandom_range(2, 5);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0: send_request(REQ_UNKNOWN, IDX_W'($urandom), IDX_W'($urandom),
                          ELEM_IN_W'($urandom));
          1, 2: send_request($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
                             IDX_W'($urandom), IDX_W'($urandom), pick_element());
          3: drain();
          default: ;
        endcase
        send_request(REQ_COMPUTE, pick_index(ra), IDX_W'($urandom), ELEM_IN_W'($urandom));
      end
      no_idle = 1'b0;
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
